/* hdl/auto_ranging_histogram_top_defines.svh */
// Assertion macros for the auto-ranging histogram.
// Included by the top level; depends on nothing else.
`ifndef AUTO_RANGING_HISTOGRAM_TOP_DEFINES_SVH
`define AUTO_RANGING_HISTOGRAM_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ARH_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ARH_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/arh_pkg.sv */
// Package for the auto-ranging histogram: field widths, codes, FSM state type.
// No dependencies.
`default_nettype none

package arh_pkg;

    localparam int SAMPLE_W    = 32;
    localparam int STATUS_W    = 2;
    localparam int IDX_OUT_W   = 4;
    localparam int COUNT_OUT_W = 32;
    localparam int SCALE_W     = 5;

    // Bin total is fixed by the 4-bit index field.
    localparam int BIN_TOTAL   = 16;

    localparam logic [SCALE_W-1:0] SCALE_LIMIT = 5'd31;

    localparam logic FUNC_ADD  = 1'b0;
    localparam logic FUNC_DUMP = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_COUNTED  = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NEGATIVE = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_DUMP     = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MERGE_RD,
        ST_MERGE_WR,
        ST_INC_WR,
        ST_DUMP_RD,
        ST_DUMP_OUT
    } arh_state_t;

    typedef struct packed {
        logic we;
        logic clr_upper;
    } arh_mem_ctl_t;

endpackage

`default_nettype wire

/* hdl/auto_ranging_histogram_top.sv */
// Auto-ranging histogram: a sample keeps busy high through a read, then a write, plus, per
// rescale, a range check, then a read and a write for each of 8 bin pairs; a dump keeps busy
// through a read and an output step per bin, a negative sample not at all. Each result shows
// for one cycle, the cycle after the edge that finishes its step; the receiver cannot stall
// results.
// Reset (rst_n, async, active low) clears all bins to zero and the scale to zero.
`default_nettype none
`include "auto_ranging_histogram_top_defines.svh"

module auto_ranging_histogram_top #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                func,
    input  logic signed [arh_pkg::SAMPLE_W-1:0] sample_value,
    output logic                                busy,
    output logic                                result_valid,
    output logic [arh_pkg::STATUS_W-1:0]        status,
    output logic [arh_pkg::IDX_OUT_W-1:0]       bin_index,
    output logic [arh_pkg::COUNT_OUT_W-1:0]     bin_count,
    output logic [arh_pkg::SCALE_W-1:0]         scale_log2,
    output logic                                last
);

    import arh_pkg::*;

    localparam int BIN_AW = $clog2(BIN_TOTAL);
    localparam int MAG_W  = SAMPLE_W - 1;
    localparam logic [BIN_AW-1:0] LAST_PAIR = BIN_AW'(BIN_TOTAL / 2 - 1);
    localparam logic [BIN_AW-1:0] LAST_BIN  = BIN_AW'(BIN_TOTAL - 1);

    // Sequencer state
    arh_state_t state_reg, state_next;

    // Working registers: sample magnitude, scale, target bin, pass counter
    logic [MAG_W-1:0]   sample_reg, sample_next;
    logic [SCALE_W-1:0] scale_reg, scale_next;
    logic [BIN_AW-1:0]  idx_reg, idx_next;
    logic [BIN_AW-1:0]  cnt_reg, cnt_next;

    // Result registers
    logic                   out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic [IDX_OUT_W-1:0]   index_reg, index_next;
    logic [COUNT_OUT_W-1:0] count_reg, count_next;
    logic [SCALE_W-1:0]     scale_out_reg, scale_out_next;
    logic                   last_reg, last_next;

    // Memory and shared adder hookup
    arh_mem_ctl_t           mem_ctl;
    logic [BIN_AW-1:0]      waddr;
    logic [BIN_AW-1:0]      raddr_a;
    logic [BIN_AW-1:0]      raddr_b;
    logic [COUNT_WIDTH-1:0] rdata_a;
    logic [COUNT_WIDTH-1:0] rdata_b;
    logic [COUNT_WIDTH-1:0] add_b;
    logic [COUNT_WIDTH-1:0] sat_sum;

    // Range check on the held sample
    logic [MAG_W-1:0]  shifted;
    logic              out_of_range;
    logic [BIN_AW-1:0] idx_clamped;

    assign shifted      = sample_reg >> scale_reg;
    assign out_of_range = (shifted >= MAG_W'(BIN_TOTAL)) && (scale_reg != SCALE_LIMIT);
    // Clamp only matters once the scale has hit its limit.
    assign idx_clamped  = (shifted >= MAG_W'(BIN_TOTAL)) ? LAST_BIN : shifted[BIN_AW-1:0];

    arh_bin_mem #(
        .DEPTH       (BIN_TOTAL),
        .COUNT_WIDTH (COUNT_WIDTH),
        .BIN_AW      (BIN_AW)
    ) u_bin_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mem_ctl),
        .waddr   (waddr),
        .wdata   (sat_sum),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    // One adder serves both the pairwise merge and the +1 increment.
    arh_sat_add #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_sat_add (
        .a   (rdata_a),
        .b   (add_b),
        .sum (sat_sum)
    );

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scale_reg     <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scale_reg     <= scale_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk) begin
        sample_reg    <= sample_next;
        idx_reg       <= idx_next;
        status_reg    <= status_next;
        index_reg     <= index_next;
        count_reg     <= count_next;
        scale_out_reg <= scale_out_next;
        last_reg      <= last_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        sample_next    = sample_reg;
        scale_next     = scale_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        out_valid_next = 1'b0;
        status_next    = status_reg;
        index_next     = index_reg;
        count_next     = count_reg;
        scale_out_next = scale_out_reg;
        last_next      = last_reg;
        mem_ctl        = '0;
        waddr          = idx_reg;
        raddr_a        = idx_clamped;
        raddr_b        = {cnt_reg[BIN_AW-2:0], 1'b1};
        add_b          = COUNT_WIDTH'(1);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (func == FUNC_DUMP)
                    begin
                        cnt_next   = '0;
                        state_next = ST_DUMP_RD;
                    end
                    else if (sample_value[SAMPLE_W-1])
                    begin
                        // Drop the negative sample and report it at once.
                        out_valid_next = 1'b1;
                        status_next    = STAT_NEGATIVE;
                        index_next     = '0;
                        count_next     = '0;
                        scale_out_next = scale_reg;
                        last_next      = 1'b1;
                    end
                    else
                    begin
                        sample_next = sample_value[MAG_W-1:0];
                        state_next  = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                if (out_of_range)
                begin
                    // Double the bin width, then merge pairs.
                    scale_next = scale_reg + SCALE_W'(1);
                    cnt_next   = '0;
                    state_next = ST_MERGE_RD;
                end
                else
                begin
                    // Fetch the target bin.
                    idx_next   = idx_clamped;
                    raddr_a    = idx_clamped;
                    state_next = ST_INC_WR;
                end
            end
            ST_MERGE_RD:
            begin
                raddr_a    = {cnt_reg[BIN_AW-2:0], 1'b0};
                raddr_b    = {cnt_reg[BIN_AW-2:0], 1'b1};
                state_next = ST_MERGE_WR;
            end
            ST_MERGE_WR:
            begin
                add_b      = rdata_b;
                mem_ctl.we = 1'b1;
                waddr      = cnt_reg;
                if (cnt_reg == LAST_PAIR)
                begin
                    // Zero the upper half and recheck the range.
                    mem_ctl.clr_upper = 1'b1;
                    state_next        = ST_CHECK;
                end
                else
                begin
                    cnt_next   = cnt_reg + BIN_AW'(1);
                    state_next = ST_MERGE_RD;
                end
            end
            ST_INC_WR:
            begin
                mem_ctl.we     = 1'b1;
                waddr          = idx_reg;
                out_valid_next = 1'b1;
                status_next    = STAT_COUNTED;
                index_next     = IDX_OUT_W'(idx_reg);
                count_next     = COUNT_OUT_W'(sat_sum);
                scale_out_next = scale_reg;
                last_next      = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_DUMP_RD:
            begin
                raddr_a    = cnt_reg;
                state_next = ST_DUMP_OUT;
            end
            ST_DUMP_OUT:
            begin
                out_valid_next = 1'b1;
                status_next    = STAT_DUMP;
                index_next     = IDX_OUT_W'(cnt_reg);
                count_next     = COUNT_OUT_W'(rdata_a);
                scale_out_next = scale_reg;
                last_next      = (cnt_reg == LAST_BIN);
                if (cnt_reg == LAST_BIN)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next   = cnt_reg + BIN_AW'(1);
                    state_next = ST_DUMP_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = out_valid_reg;
    assign status       = status_reg;
    assign bin_index    = index_reg;
    assign bin_count    = count_reg;
    assign scale_log2   = scale_out_reg;
    assign last         = last_reg;

    // Sample and negative results are always the only result of their item.
    `ARH_ASSERT_IMP(a_single_last, clk, rst_n, result_valid && status != STAT_DUMP, last, "single result without last")
    // A merge write only ever follows a scale increment.
    `ARH_ASSERT_IMP(a_merge_scaled, clk, rst_n, state_reg == ST_MERGE_WR, scale_reg != '0, "merge at zero scale")
    // An incremented bin can never read back as zero.
    `ARH_ASSERT_IMP(a_inc_nonzero, clk, rst_n, state_reg == ST_INC_WR, sat_sum != '0, "increment gave zero")
    // An accepted nonnegative sample must raise busy on the next cycle.
    `ARH_ASSERT_NXT(a_sample_busy, clk, rst_n, start && !busy && func == FUNC_ADD && !sample_value[SAMPLE_W-1], busy, "sample not taken")

endmodule

`default_nettype wire

/* hdl/arh_sat_add.sv */
// Saturating adder shared by bin merges and sample increments.
// No dependencies.
`default_nettype none

module arh_sat_add #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic [COUNT_WIDTH-1:0] a,
    input  logic [COUNT_WIDTH-1:0] b,
    output logic [COUNT_WIDTH-1:0] sum
);

    logic [COUNT_WIDTH:0] raw;

    assign raw = {1'b0, a} + {1'b0, b};
    // Clamp on carry out: the count holds its largest value.
    assign sum = raw[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : raw[COUNT_WIDTH-1:0];

endmodule

`default_nettype wire

/* hdl/arh_bin_mem.sv */
// Bin count store: one write port, two registered read ports, per-bin valid bits.
// Depends on arh_pkg for the control struct.
`default_nettype none

module arh_bin_mem #(
    parameter int DEPTH       = 16,
    parameter int COUNT_WIDTH = 32,
    parameter int BIN_AW      = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  arh_pkg::arh_mem_ctl_t  ctl,
    input  logic [BIN_AW-1:0]      waddr,
    input  logic [COUNT_WIDTH-1:0] wdata,
    input  logic [BIN_AW-1:0]      raddr_a,
    input  logic [BIN_AW-1:0]      raddr_b,
    output logic [COUNT_WIDTH-1:0] rdata_a,
    output logic [COUNT_WIDTH-1:0] rdata_b
);

    import arh_pkg::*;

    logic [COUNT_WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0]       valid_reg;
    logic [DEPTH-1:0]       valid_next;
    logic [COUNT_WIDTH-1:0] data_a_reg;
    logic [COUNT_WIDTH-1:0] data_b_reg;
    logic                   vld_a_reg;
    logic                   vld_b_reg;

    always_ff @(posedge clk) begin
        if (ctl.we)
        begin
            mem[waddr] <= wdata;
        end
        data_a_reg <= mem[raddr_a];
        data_b_reg <= mem[raddr_b];
    end

    // Set on write; drop the upper half after a merge pass.
    always_comb
    begin
        valid_next = valid_reg;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (ctl.clr_upper && i >= DEPTH / 2)
            begin
                valid_next[i] = 1'b0;
            end
            else if (ctl.we && waddr == BIN_AW'(i))
            begin
                valid_next[i] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            vld_a_reg <= valid_reg[raddr_a];
            vld_b_reg <= valid_reg[raddr_b];
        end
    end

    assign rdata_a = vld_a_reg ? data_a_reg : '0;
    assign rdata_b = vld_b_reg ? data_b_reg : '0;

endmodule

`default_nettype wire

/* test/arh_checker.sv */
// Checker for the auto-ranging histogram: watches the command and result ports,
// keeps its own copy of the bins and the scale, and compares each result field.
// Depends on arh_pkg for the func and status codes.
`default_nettype none

module arh_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        func,
    input  logic [31:0] sample_value,
    input  logic        busy,
    input  logic        result_valid,
    input  logic [1:0]  status,
    input  logic [3:0]  bin_index,
    input  logic [31:0] bin_count,
    input  logic [4:0]  scale_log2,
    input  logic        last,
    output int          mismatches,
    output int          pending,
    output int          results_checked
);
    import arh_pkg::*;

    localparam int BINS = 16;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  bin;
        logic [31:0] tally;
        logic [4:0]  span;
        logic        is_last;
    } bin_result_t;

    bin_result_t expected_bins[$];
    logic [31:0] bin_tally [BINS];
    logic [4:0]  span_log2;

    function automatic logic [31:0] sat_sum(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? '1 : s[31:0];
    endfunction

    // Double the bin span: fold pairs into the lower half, clear the upper half.
    task automatic merge_bin_pairs();
        for (int i = 0; i < BINS / 2; i++)
            bin_tally[i] = sat_sum(bin_tally[2 * i], bin_tally[2 * i + 1]);
        for (int i = BINS / 2; i < BINS; i++)
            bin_tally[i] = '0;
    endtask

    task automatic predict_histogram(input logic f, input logic [31:0] v);
        bin_result_t r;
        logic [31:0] sel;
        if (f == FUNC_DUMP) begin
            for (int i = 0; i < BINS; i++) begin
                r.status  = STAT_DUMP;
                r.bin     = i[3:0];
                r.tally   = bin_tally[i];
                r.span    = span_log2;
                r.is_last = (i == BINS - 1);
                expected_bins.push_back(r);
            end
        end
        else if (v[31]) begin
            r.status  = STAT_NEGATIVE;
            r.bin     = '0;
            r.tally   = '0;
            r.span    = span_log2;
            r.is_last = 1'b1;
            expected_bins.push_back(r);
        end
        else begin
            while ((v >> span_log2) >= BINS && span_log2 < SCALE_LIMIT) begin
                span_log2 = span_log2 + 5'd1;
                merge_bin_pairs();
            end
            sel = v >> span_log2;
            if (sel >= BINS)
                sel = BINS - 1;
            bin_tally[sel[3:0]] = sat_sum(bin_tally[sel[3:0]], 32'd1);
            r.status  = STAT_COUNTED;
            r.bin     = sel[3:0];
            r.tally   = bin_tally[sel[3:0]];
            r.span    = span_log2;
            r.is_last = 1'b1;
            expected_bins.push_back(r);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $error("%s: expected %0d, actual %0d", name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        bin_result_t head;
        if (!rst_n) begin
            for (int i = 0; i < BINS; i++)
                bin_tally[i] = '0;
            span_log2 = '0;
            expected_bins.delete();
            mismatches      = 0;
            results_checked = 0;
        end
        else begin
            // Results seen at this edge are older than any item taken at it.
            if (result_valid) begin
                if (expected_bins.size() == 0) begin
                    mismatches++;
                    $error("result with nothing outstanding: status %0d bin_index %0d",
                           status, bin_index);
                end
                else begin
                    head = expected_bins.pop_front();
                    check_field("status", head.status, status);
                    check_field("bin_index", head.bin, bin_index);
                    check_field("bin_count", head.tally, bin_count);
                    check_field("scale_log2", head.span, scale_log2);
                    check_field("last", head.is_last, last);
                    results_checked++;
                end
            end
            if (start && !busy)
                predict_histogram(func, sample_value);
        end
        pending = expected_bins.size();
    end

endmodule

`default_nettype wire

/* test/tb.sv */
// Testbench top for the auto-ranging histogram: clock, reset, command stimulus,
// watchdog and verdict. Depends on arh_pkg, auto_ranging_histogram_top and arh_checker.
`default_nettype none

module tb;
    import arh_pkg::*;

    localparam int RANDOM_ITEMS = 315;
    // Worst single item: 27 rescales, far below this.
    localparam int QUIET_LIMIT  = 4000;
    // Settle time after the last result before the verdict.
    localparam int DRAIN_CYCLES = 40;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               func = FUNC_ADD;
    logic signed [31:0] sample_value = '0;
    logic               busy;
    logic               result_valid;
    logic [1:0]         status;
    logic [3:0]         bin_index;
    logic [31:0]        bin_count;
    logic [4:0]         scale_log2;
    logic               last;

    int mismatches;
    int pending;
    int results_checked;
    int quiet_cycles = 0;

    // Stimulus bookkeeping: what went in, and the scale the block should be at.
    int       samples_sent = 0;
    int       negatives_sent = 0;
    int       dumps_sent = 0;
    logic [4:0] scale_mirror = '0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    auto_ranging_histogram_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .func         (func),
        .sample_value (sample_value),
        .busy         (busy),
        .result_valid (result_valid),
        .status       (status),
        .bin_index    (bin_index),
        .bin_count    (bin_count),
        .scale_log2   (scale_log2),
        .last         (last)
    );

    arh_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .func            (func),
        .sample_value    (sample_value),
        .busy            (busy),
        .result_valid    (result_valid),
        .status          (status),
        .bin_index       (bin_index),
        .bin_count       (bin_count),
        .scale_log2      (scale_log2),
        .last            (last),
        .mismatches      (mismatches),
        .pending         (pending),
        .results_checked (results_checked)
    );

    // Call at a falling edge. Raise start with the item, hold it until an edge
    // finds busy low, then return at the next falling edge with start still high,
    // so a following item in the same burst goes out without a gap.
    task automatic send_item(input logic f, input logic [31:0] v);
        start        <= 1'b1;
        func         <= f;
        sample_value <= v;
        do
            @(posedge clk);
        while (busy);
        if (f == FUNC_DUMP)
            dumps_sent++;
        else if (v[31])
            negatives_sent++;
        else
        begin
            samples_sent++;
            // Track the scale so the random part can aim inside or past the range.
            while ((v >> scale_mirror) >= 16)
                scale_mirror++;
        end
        @(negedge clk);
    endtask

    // Mostly samples inside the current range, so the bins fill up between
    // rescales; now and then a sample one or two scale steps past the top,
    // plus negative samples and dumps. Dumps carry random, ignored values.
    task automatic make_random_item(output logic f, output logic [31:0] v);
        int          pick;
        int          top_log2;
        logic [31:0] lo;
        logic [31:0] hi;
        pick = $urandom_range(0, 99);
        f    = FUNC_ADD;
        if (pick < 10)
        begin
            f = FUNC_DUMP;
            v = $urandom();
        end
        else if (pick < 25)
            v = $urandom() | 32'h8000_0000;
        else if (pick < 31 && scale_mirror < 27)
        begin
            top_log2 = scale_mirror + $urandom_range(1, 2);
            if (top_log2 > 27)
                top_log2 = 27;
            lo = 32'd16 << scale_mirror;
            hi = (32'd16 << top_log2) - 32'd1;
            // Hit the first value past the range exactly now and then.
            v  = ($urandom_range(0, 3) == 0) ? lo : $urandom_range(hi, lo);
        end
        else
        begin
            hi = (32'd16 << scale_mirror) - 32'd1;
            case ($urandom_range(0, 9))
                0:       v = hi;
                1:       v = '0;
                default: v = $urandom_range(hi, 0);
            endcase
        end
    endtask

    // Hold start low and wait for every outstanding result.
    task automatic drain_results();
        start <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
    endtask

    // Count cycles in which neither an item nor a result moves; give up at the limit.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: %0d cycles without progress, %0d results outstanding",
                     quiet_cycles, pending);
            $display("Mismatches found");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        logic        f;
        logic [31:0] v;
        int          random_sent;
        int          burst_len;

        random_sent = 0;

        // Hold reset, then release it at a falling edge.
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: range edges at scale zero, both negative extremes, dumps,
        // a single rescale, a double rescale, back to back with no gaps.
        send_item(FUNC_ADD, 32'd0);
        send_item(FUNC_ADD, 32'd15);
        send_item(FUNC_ADD, 32'd7);
        send_item(FUNC_ADD, 32'hFFFF_FFFF);
        send_item(FUNC_ADD, 32'h8000_0000);
        send_item(FUNC_DUMP, 32'd0);
        send_item(FUNC_ADD, 32'd16);
        send_item(FUNC_ADD, 32'd31);
        send_item(FUNC_ADD, 32'd64);
        send_item(FUNC_ADD, 32'd127);
        send_item(FUNC_DUMP, 32'hFFFF_FFFF);
        send_item(FUNC_ADD, 32'd1);

        // Let the block run dry once before the random traffic.
        drain_results();

        // Random traffic in bursts; random gaps between bursts land on every
        // phase of a step, and an occasional full drain empties the pipeline.
        while (random_sent < RANDOM_ITEMS)
        begin
            burst_len = $urandom_range(1, 12);
            for (int n = 0; n < burst_len && random_sent < RANDOM_ITEMS; n++)
            begin
                make_random_item(f, v);
                send_item(f, v);
                random_sent++;
            end
            if ($urandom_range(0, 19) == 0)
                drain_results();
            else
            begin
                // Drop start and wiggle the payload while nothing is offered.
                start        <= 1'b0;
                func         <= 1'($urandom_range(0, 1));
                sample_value <= $urandom();
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end
        end

        // Ceiling: the largest sample jumps to the widest bins, then a last dump.
        drain_results();
        send_item(FUNC_ADD, 32'h7FFF_FFFF);
        send_item(FUNC_ADD, 32'h7FFF_FFFF);
        send_item(FUNC_ADD, 32'd0);
        send_item(FUNC_ADD, 32'h0800_0000);
        send_item(FUNC_DUMP, $urandom());
        start <= 1'b0;

        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d counted samples, %0d negative samples and %0d dumps;",
                 samples_sent, negatives_sent, dumps_sent);
        $display("%0d results compared, bins widened up to a span of 2^%0d.",
                 results_checked, scale_mirror);
        if (mismatches == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
